>>> sv/mmps_pkg.sv
// Shared constants and types for the modular matrix power sum block.
`timescale 1ns / 1ps
package mmps_pkg;
  localparam int MaxDim = 32;
  localparam int DimW = $clog2(MaxDim);
  localparam int AddrW = 2 * DimW;
  localparam int Depth = 1 << AddrW;
  localparam int ValW = 30;
  localparam int ExpW = 60;
  localparam int SizeW = 6;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 60;
  localparam logic [CfgIdxW-1:0] REG_SIZE = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_EXP = 1'b1;
  localparam logic [ValW-1:0] Prime = 30'd998244353;
  // floor(2^60 / Prime), for the Barrett quotient estimate
  localparam logic [30:0] BarrettMu = 31'd1154949187;

  typedef logic [ValW-1:0] val_t;
  typedef logic [AddrW-1:0] addr_t;
  typedef logic [DimW-1:0] dim_t;

  // Control between sequencer and MAC unit.
  typedef struct packed {
    logic clr;   // start new dot product
    logic en;    // accumulate the product of this cycle's operands
  } mac_ctl_t;
endpackage

>>> sv/mmps_if.sv
// Valid/ready channel interfaces for the modular matrix power sum block.
`timescale 1ns / 1ps
interface mmps_in_if (input logic clk);
  logic valid;
  logic ready;
  logic [mmps_pkg::ValW-1:0] entry_value;
  logic last_entry;
  modport source (output valid, entry_value, last_entry, input ready);
  modport sink (input valid, entry_value, last_entry, output ready);
endinterface

interface mmps_out_if (input logic clk);
  logic valid;
  logic ready;
  logic [mmps_pkg::ValW-1:0] entry_sum;
  modport source (output valid, entry_sum, input ready);
  modport sink (input valid, entry_sum, output ready);
endinterface

>>> sv/mmps_ram.sv
// Generic single-port-write, single-read RAM with registered read.
`timescale 1ns / 1ps
module mmps_ram #(
  parameter int Width = 30,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> sv/mmps_mac.sv
// Modular multiply-accumulate unit: acc = (acc + a*b) mod prime, 4 stages.
`timescale 1ns / 1ps
module mmps_mac (
  input  logic               clk,
  input  mmps_pkg::mac_ctl_t ctl,
  input  mmps_pkg::val_t     a,
  input  mmps_pkg::val_t     b,
  output mmps_pkg::val_t     acc
);
  // Stage 1: product. Stage 2: Barrett quotient estimate from the top bits.
  // Stage 3: remainder, at most two fix-up subtracts. Stage 4: accumulate.
  logic [59:0] prod_r, prod2_r;
  logic        en1_r, clr1_r, en2_r, clr2_r, en3_r, clr3_r;
  logic [61:0] qmul_r;
  logic [30:0] qhat_c;
  logic [61:0] qp_c;
  logic [59:0] rem_c;
  logic [31:0] r_c;
  mmps_pkg::val_t red_r;
  logic [30:0] sum_c;
  logic [30:0] acc_c;

  always_ff @(posedge clk) begin
    prod_r <= 60'(a) * 60'(b);
    en1_r <= ctl.en;
    clr1_r <= ctl.clr;
    qmul_r <= 62'(prod_r[59:29]) * 62'(mmps_pkg::BarrettMu);
    prod2_r <= prod_r;
    en2_r <= en1_r;
    clr2_r <= clr1_r;
  end

  always_comb begin
    qhat_c = qmul_r[61:31];
    qp_c = 62'(qhat_c) * 62'(mmps_pkg::Prime);
    rem_c = prod2_r - qp_c[59:0];
    r_c = rem_c[31:0];
    if (r_c >= 32'(mmps_pkg::Prime)) r_c = r_c - 32'(mmps_pkg::Prime);
    if (r_c >= 32'(mmps_pkg::Prime)) r_c = r_c - 32'(mmps_pkg::Prime);
  end

  always_ff @(posedge clk) begin
    red_r <= r_c[29:0];
    en3_r <= en2_r;
    clr3_r <= clr2_r;
  end

  always_comb begin
    sum_c = 31'(red_r) + 31'(clr3_r ? 30'd0 : acc);
    acc_c = (sum_c >= 31'(mmps_pkg::Prime)) ? sum_c - 31'(mmps_pkg::Prime) : sum_c;
  end

  always_ff @(posedge clk) begin
    if (en3_r) acc <= acc_c[29:0];
    else if (clr3_r) acc <= '0;
  end
endmodule

>>> sv/modular_matrix_power_sum.sv
// Top level: matrix load, square-and-multiply sequencer, entry sum.
`timescale 1ns / 1ps
// Entries are taken one per cycle while loading and written into the base
// matrix memory. The entry flagged last starts the computation, during which
// in.ready is low. For an exponent of bit length L with W set bits there are
// L + W matrix products; each is a multiply-accumulate pass, a copy of the
// product back, a pipeline drain and the choice of the next step. The identity
// is written first, and a final sum pass and a last drain follow the products.
// One shared modular multiply-accumulate unit, pipelined as registered memory
// read, product, quotient, remainder and accumulate, does every product and
// the final sum. The single result waits in an output register while the
// next matrix loads; if it is still not taken when the next computation ends,
// the block holds there with in.ready low. Memories need no clearing after
// reset.
module modular_matrix_power_sum (
  input  logic                                clk,
  input  logic                                rst_n,
  mmps_in_if.sink                             in_ch,
  mmps_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [mmps_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [mmps_pkg::CfgDataW-1:0]       cfg_data
);
  localparam logic [3:0] S_LOAD = 4'd0, S_IDENT = 4'd1, S_MUL = 4'd2,
    S_DRAIN = 4'd3, S_COPY = 4'd4, S_COPYW = 4'd5, S_NEXT = 4'd6,
    S_SUM = 4'd7, S_SUMW = 4'd8, S_OUT = 4'd9;
  localparam int Lat = 5; // read + product + quotient + remainder + accumulate

  logic [mmps_pkg::SizeW-1:0] size_r;
  logic [mmps_pkg::ExpW-1:0] exp_cfg_r, rem_r;
  logic [3:0] st_r;
  logic [mmps_pkg::DimW:0] n_c;
  logic [mmps_pkg::AddrW:0] load_idx_r;
  mmps_pkg::dim_t li_r, lj_r, i_r, j_r, k_r;
  logic sq_r; // 0: accum*=base, 1: base*=base
  logic [Lat-1:0] pipe_v_r, pipe_last_r;
  mmps_pkg::addr_t wb_addr_r [Lat];
  logic [Lat-1:0] pipe_clr_r;
  mmps_pkg::val_t sum_r;
  logic out_v_r;
  logic out_load_c;

  mmps_pkg::addr_t b_ra, a_ra, s_ra, b_wa, a_wa, s_wa;
  mmps_pkg::val_t b_wd, a_wd, b_rd, a_rd, s_rd, mac_acc;
  logic b_we, a_we, s_we;
  mmps_pkg::mac_ctl_t mctl;
  mmps_pkg::val_t ma, mb;
  logic in_fire, lhs_base_c;
  mmps_pkg::val_t vin;

  always_comb begin
    if (size_r == '0) n_c = (mmps_pkg::DimW+1)'(1);
    else if (size_r > mmps_pkg::SizeW'(mmps_pkg::MaxDim)) n_c = (mmps_pkg::DimW+1)'(mmps_pkg::MaxDim);
    else n_c = (mmps_pkg::DimW+1)'(size_r);
  end

  function automatic mmps_pkg::addr_t rc(mmps_pkg::dim_t r, mmps_pkg::dim_t c);
    return {r, c};
  endfunction

  assign in_fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (st_r == S_LOAD);
  assign out_ch.valid = out_v_r;
  assign out_ch.entry_sum = sum_r;
  // load the output register once it is empty or being emptied
  assign out_load_c = (st_r == S_OUT) && (!out_v_r || out_ch.ready);
  assign vin = (in_ch.entry_value >= mmps_pkg::Prime) ?
    in_ch.entry_value - mmps_pkg::Prime : in_ch.entry_value;
  assign lhs_base_c = sq_r;

  // Memory addressing
  always_comb begin
    b_we = 1'b0; b_wa = '0; b_wd = vin;
    a_we = 1'b0; a_wa = rc(i_r, j_r); a_wd = '0;
    s_we = pipe_v_r[Lat-1] && pipe_last_r[Lat-1];
    s_wa = wb_addr_r[Lat-1];
    b_ra = rc(k_r, j_r); a_ra = rc(i_r, k_r); s_ra = rc(i_r, j_r);
    if (st_r == S_MUL && lhs_base_c) b_ra = rc(i_r, k_r);
    if (st_r == S_SUM) a_ra = rc(i_r, j_r);
    if (st_r == S_LOAD && in_fire &&
        load_idx_r < (mmps_pkg::AddrW+1)'(n_c) * (mmps_pkg::AddrW+1)'(n_c)) begin
      b_we = 1'b1; b_wa = rc(li_r, lj_r);
    end
    if (st_r == S_IDENT) begin
      a_we = 1'b1; a_wd = (i_r == j_r) ? mmps_pkg::val_t'(1) : '0;
    end
    if (st_r == S_COPYW) begin
      if (sq_r) begin b_we = 1'b1; b_wa = wb_addr_r[0]; b_wd = s_rd; end
      else begin a_we = 1'b1; a_wa = wb_addr_r[0]; a_wd = s_rd; end
    end
  end

  // base*base needs two base reads; use the B port for the left operand and
  // route the right operand through a second base copy kept equal (mirror).
  mmps_pkg::val_t m_rd;
  mmps_pkg::addr_t m_ra;
  assign m_ra = rc(k_r, j_r);

  mmps_ram #(.Width(mmps_pkg::ValW), .Depth(mmps_pkg::Depth)) u_base (
    .clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));
  mmps_ram #(.Width(mmps_pkg::ValW), .Depth(mmps_pkg::Depth)) u_mirror (
    .clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(m_ra), .rdata(m_rd));
  mmps_ram #(.Width(mmps_pkg::ValW), .Depth(mmps_pkg::Depth)) u_accum (
    .clk(clk), .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(a_ra), .rdata(a_rd));
  mmps_ram #(.Width(mmps_pkg::ValW), .Depth(mmps_pkg::Depth)) u_scratch (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(mac_acc), .raddr(s_ra), .rdata(s_rd));

  // Operand select, in the cycle after the read is issued.
  logic op_sq_r, op_sum_r;
  always_ff @(posedge clk) begin
    op_sq_r <= sq_r;
    op_sum_r <= (st_r == S_SUM);
  end
  always_comb begin
    ma = op_sq_r ? b_rd : a_rd;
    mb = op_sq_r ? m_rd : b_rd;
    if (op_sum_r) begin ma = a_rd; mb = mmps_pkg::val_t'(1); end
  end
  assign mctl.en = pipe_v_r[0];
  assign mctl.clr = pipe_clr_r[0];

  mmps_mac u_mac (.clk(clk), .ctl(mctl), .a(ma), .b(mb), .acc(mac_acc));

  logic last_k_c, last_j_c, last_i_c, issue_c, first_c;
  assign last_k_c = ({1'b0, k_r} == n_c - 1'b1);
  assign last_j_c = ({1'b0, j_r} == n_c - 1'b1);
  assign last_i_c = ({1'b0, i_r} == n_c - 1'b1);
  assign issue_c = (st_r == S_MUL) || (st_r == S_SUM);
  assign first_c = (st_r == S_SUM) ? (i_r == '0 && j_r == '0) : (k_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 6'd1; exp_cfg_r <= 60'd1; rem_r <= '0; st_r <= S_LOAD;
      load_idx_r <= '0; li_r <= '0; lj_r <= '0; i_r <= '0; j_r <= '0; k_r <= '0;
      sq_r <= 1'b0; pipe_v_r <= '0; pipe_last_r <= '0; pipe_clr_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == mmps_pkg::REG_SIZE) size_r <= cfg_data[mmps_pkg::SizeW-1:0];
      if (cfg_we && cfg_index == mmps_pkg::REG_EXP) exp_cfg_r <= cfg_data;
      // advance the MAC pipeline tags; the MAC itself sees operands after the registered memory read
      pipe_v_r <= {pipe_v_r[Lat-2:0], issue_c};
      pipe_clr_r <= {pipe_clr_r[Lat-2:0], issue_c && first_c};
      pipe_last_r <= {pipe_last_r[Lat-2:0],
                      issue_c && (st_r == S_SUM ? (last_i_c && last_j_c) : last_k_c)};
      wb_addr_r[0] <= (st_r == S_COPY) ? rc(i_r, j_r) : rc(i_r, j_r);
      for (int p = 1; p < Lat; p++) wb_addr_r[p] <= wb_addr_r[p-1];
      if (out_load_c) out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
      case (st_r)
        S_LOAD: if (in_fire) begin
          if (in_ch.last_entry) begin
            load_idx_r <= '0; li_r <= '0; lj_r <= '0;
            i_r <= '0; j_r <= '0; k_r <= '0; st_r <= S_IDENT;
            rem_r <= exp_cfg_r;
          end else if (load_idx_r < (mmps_pkg::AddrW+1)'(n_c) * (mmps_pkg::AddrW+1)'(n_c)) begin
            load_idx_r <= load_idx_r + 1'b1;
            if ({1'b0, lj_r} == n_c - 1'b1) begin lj_r <= '0; li_r <= li_r + 1'b1; end
            else lj_r <= lj_r + 1'b1;
          end
        end
        S_IDENT: begin
          if (last_j_c) begin
            j_r <= '0;
            if (last_i_c) begin i_r <= '0; st_r <= S_NEXT; end
            else i_r <= i_r + 1'b1;
          end else j_r <= j_r + 1'b1;
        end
        S_NEXT: begin
          i_r <= '0; j_r <= '0; k_r <= '0;
          if (rem_r == '0) st_r <= S_SUM;
          else if (rem_r[0] && !sq_r) st_r <= S_MUL;
          else begin sq_r <= 1'b1; st_r <= S_MUL; end
        end
        S_MUL: begin
          if (last_k_c) begin
            k_r <= '0;
            if (last_j_c) begin
              j_r <= '0;
              if (last_i_c) begin i_r <= '0; st_r <= S_DRAIN; end
              else i_r <= i_r + 1'b1;
            end else j_r <= j_r + 1'b1;
          end else k_r <= k_r + 1'b1;
        end
        S_DRAIN: if (pipe_v_r == '0) st_r <= S_COPY;
        S_COPY: st_r <= S_COPYW;  // issue scratch read
        S_COPYW: begin
          if (last_j_c) begin
            j_r <= '0;
            if (last_i_c) begin
              i_r <= '0; st_r <= S_NEXT;
              // after the accumulate product the square of this bit follows
              if (sq_r) begin sq_r <= 1'b0; rem_r <= rem_r >> 1; end
              else sq_r <= 1'b1;
            end else begin
              i_r <= i_r + 1'b1; st_r <= S_COPY;
            end
          end else begin
            j_r <= j_r + 1'b1; st_r <= S_COPY;
          end
        end
        S_SUM: begin
          if (last_j_c) begin
            j_r <= '0;
            if (last_i_c) begin i_r <= '0; st_r <= S_SUMW; end
            else i_r <= i_r + 1'b1;
          end else j_r <= j_r + 1'b1;
        end
        S_SUMW: if (pipe_v_r == '0) st_r <= S_OUT;
        S_OUT: if (out_load_c) st_r <= S_LOAD;
        default: st_r <= S_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) if (out_load_c) sum_r <= mac_acc;

  // The MAC result is written to scratch only at the end of a dot product.
  // While not loading, no input transaction is taken; a held result stays stable, and no copy starts before the drain.
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_LOAD) |-> !in_ch.ready) else $error("ready while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready |=> out_v_r && $stable(sum_r)) else $error("result lost");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_COPY) |-> (pipe_v_r == '0)) else $error("copy before drain");
endmodule

>>> tb/tb_modular_matrix_power_sum.sv
// Testbench for the modular matrix power sum block: matrix loads, powers, sum checks.
`timescale 1ns / 1ps
module tb_modular_matrix_power_sum;
  localparam longint unsigned PRIME_L = 64'd998244353;
  localparam int unsigned CYCLE_LIMIT = 6000000;
  localparam int unsigned RANDOM_ITEMS = 60;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int MaxDim = mmps_pkg::MaxDim;
  localparam int CfgW = mmps_pkg::CfgDataW;

  typedef longint unsigned matrix_t [0:MaxDim-1][0:MaxDim-1];

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [mmps_pkg::CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0] cfg_data;

  mmps_in_if in_if (clk);
  mmps_out_if out_if (clk);

  modular_matrix_power_sum dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_if),
    .out_ch(out_if),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow copy of the block: registers, load position and the base matrix.
  logic [mmps_pkg::SizeW-1:0] size_reg;
  logic [mmps_pkg::ExpW-1:0] exp_reg;
  int unsigned load_pos;
  matrix_t base_m;
  bit written_m [0:MaxDim-1][0:MaxDim-1];

  mmps_pkg::val_t sums_pending[$];
  int unsigned errors;
  int unsigned sums_checked;
  int unsigned entries_sent;
  int unsigned cycle_count;
  int unsigned in_idle_pct;
  int unsigned out_idle_pct;
  int unsigned hold_left;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Give up on a hung block.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: a requested hold-off wins over the random idling.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_if.ready = 1'b0;
      hold_left--;
    end else begin
      out_if.ready = ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  // Compare every result transaction with the oldest pending sum.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (sums_pending.size() == 0) begin
        $error("entry_sum: unexpected result %0d", out_if.entry_sum);
        errors++;
      end else begin
        mmps_pkg::val_t want;
        want = sums_pending.pop_front();
        if (out_if.entry_sum !== want) begin
          $error("entry_sum: expected %0d, got %0d", want, out_if.entry_sum);
          errors++;
        end
        sums_checked++;
      end
    end
  end

  function automatic int unsigned active_dim();
    if (size_reg == 0) return 1;
    if (size_reg > MaxDim) return MaxDim;
    return size_reg;
  endfunction

  // Product of the leading n x n blocks, reduced after every multiply-add.
  function automatic matrix_t mat_product(matrix_t a, matrix_t b, int unsigned n);
    matrix_t r;
    longint unsigned acc;
    r = a;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        acc = 0;
        for (int k = 0; k < n; k++) begin
          acc += a[i][k] * b[k][j];
          acc %= PRIME_L;
        end
        r[i][j] = acc;
      end
    return r;
  endfunction

  // Update the shadow state for one accepted entry; queue the sum on a last entry.
  function automatic void predict_entry(mmps_pkg::val_t value, logic last);
    int unsigned n;
    longint unsigned v;
    longint unsigned sum;
    logic [mmps_pkg::ExpW-1:0] e;
    matrix_t acc_m;
    n = active_dim();
    v = value;
    if (v >= PRIME_L) v -= PRIME_L;
    if (load_pos < n * n) begin
      base_m[load_pos / n][load_pos % n] = v;
      written_m[load_pos / n][load_pos % n] = 1'b1;
      load_pos++;
    end
    if (!last) return;
    load_pos = 0;
    acc_m = base_m;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        acc_m[i][j] = (i == j) ? 1 : 0;
    e = exp_reg;
    while (e != 0) begin
      if (e[0]) acc_m = mat_product(acc_m, base_m, n);
      base_m = mat_product(base_m, base_m, n);
      e >>= 1;
    end
    sum = 0;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        sum = (sum + acc_m[i][j]) % PRIME_L;
    sums_pending = {sums_pending, mmps_pkg::val_t'(sum)};
  endfunction

  function automatic bit block_written(int unsigned n);
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        if (!written_m[i][j]) return 1'b0;
    return 1'b1;
  endfunction

  // Start and end at a falling edge; hold valid until the transaction goes through.
  task automatic send_entry(mmps_pkg::val_t value, logic last);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.entry_value = value;
    in_if.last_entry = last;
    do @(posedge clk); while (!in_if.ready);
    predict_entry(value, last);
    entries_sent++;
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (sums_pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Registers change only with the block idle.
  task automatic write_reg(logic [mmps_pkg::CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    wait_idle();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    if (idx == mmps_pkg::REG_SIZE) size_reg = data[mmps_pkg::SizeW-1:0];
    else exp_reg = data[mmps_pkg::ExpW-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic mmps_pkg::val_t pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return mmps_pkg::val_t'(PRIME_L - 1);
      2: return mmps_pkg::val_t'($urandom_range(998244353, 32'h3FFF_FFFF));
      3: return mmps_pkg::val_t'($urandom_range(0, 3));
      default: return mmps_pkg::val_t'($urandom);
    endcase
  endfunction

  function automatic logic [mmps_pkg::ExpW-1:0] pick_exponent();
    int unsigned bits;
    logic [63:0] raw;
    bits = $urandom_range(0, mmps_pkg::ExpW);
    raw = {$urandom, $urandom};
    if (bits == 0) return '0;
    raw = raw & ((64'd1 << bits) - 1);
    raw[bits - 1] = 1'b1;
    return raw[mmps_pkg::ExpW-1:0];
  endfunction

  // One load of count entries, the last one flagged.
  task automatic send_load(int unsigned count);
    for (int unsigned k = 0; k < count; k++)
      send_entry(pick_value(), k == count - 1);
  endtask

  task automatic test_directed();
    write_reg(mmps_pkg::REG_SIZE, CfgW'(1));
    write_reg(mmps_pkg::REG_EXP, CfgW'(1));
    send_entry('0, 1'b1);
    send_entry(mmps_pkg::val_t'(PRIME_L - 1), 1'b1);
    send_entry(30'h3FFF_FFFF, 1'b1);           // unreduced entry
    send_entry(mmps_pkg::val_t'(PRIME_L), 1'b1); // exactly the prime
    write_reg(mmps_pkg::REG_EXP, 60'hFFF_FFFF_FFFF_FFFF);
    send_entry(30'd2, 1'b1);
    write_reg(mmps_pkg::REG_SIZE, CfgW'(0));   // size zero acts as one
    send_entry(30'd3, 1'b1);
    write_reg(mmps_pkg::REG_SIZE, CfgW'(2));
    write_reg(mmps_pkg::REG_EXP, CfgW'(0));    // identity: sum is the size
    send_load(4);
    write_reg(mmps_pkg::REG_EXP, CfgW'(3));
    send_load(6);                              // two surplus entries dropped
    send_entry(30'd5, 1'b1);                   // short load keeps old entries
    write_reg(mmps_pkg::REG_EXP, 60'hFFF_FFFF_FFFF_FFFF);
    send_load(4);
  endtask

  // Groups of loads under one setting, sizes kept small so powers stay cheap.
  task automatic test_random(int unsigned budget);
    int unsigned start;
    int unsigned n;
    int unsigned count;
    start = entries_sent;
    while (entries_sent - start < budget) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
      write_reg(mmps_pkg::REG_SIZE, CfgW'(n));
      write_reg(mmps_pkg::REG_EXP, (n > 4) ? 60'($urandom_range(0, 15)) : pick_exponent());
      repeat ($urandom_range(2, 6)) begin
        count = n * n;
        case ($urandom_range(0, 9))
          0, 1: count = n * n + $urandom_range(1, 3);
          2: if (block_written(n)) count = $urandom_range(1, n * n);
          default: ;
        endcase
        if (entries_sent - start < budget) send_load(count);
      end
    end
  endtask

  task automatic test_full_size();
    write_reg(mmps_pkg::REG_SIZE, CfgW'(MaxDim));
    write_reg(mmps_pkg::REG_EXP, CfgW'(1));
    send_load(MaxDim * MaxDim);
    write_reg(mmps_pkg::REG_SIZE, CfgW'(63));  // above the maximum: clamps
    write_reg(mmps_pkg::REG_EXP, CfgW'(0));
    send_entry(mmps_pkg::val_t'(PRIME_L - 1), 1'b1);
  endtask

  // Hold the receiver off while loads keep coming, so the block backs up.
  task automatic test_backpressure();
    write_reg(mmps_pkg::REG_SIZE, CfgW'(2));
    write_reg(mmps_pkg::REG_EXP, CfgW'(5));
    @(posedge clk);
    hold_left = 600;
    @(negedge clk);
    repeat (3) send_load(4);
    wait_idle();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.entry_value = '0;
    in_if.last_entry = 1'b0;
    out_if.ready = 1'b0;
    size_reg = 1;
    exp_reg = 1;
    load_pos = 0;
    errors = 0;
    sums_checked = 0;
    entries_sent = 0;
    cycle_count = 0;
    hold_left = 0;
    in_idle_pct = 0;
    out_idle_pct = 0;
    foreach (written_m[i, j]) written_m[i][j] = 1'b0;
    foreach (base_m[i, j]) base_m[i][j] = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    in_idle_pct = 22;
    out_idle_pct = 88;
    test_directed();
    test_random(RANDOM_ITEMS / 3);
    test_backpressure();
    in_idle_pct = 88;
    out_idle_pct = 22;
    test_random(RANDOM_ITEMS / 3);
    in_idle_pct = 0;
    out_idle_pct = 0;
    test_random(RANDOM_ITEMS / 3);
    test_full_size();
    wait_idle();
    repeat (50) @(negedge clk);

    $display("Covered %0d entries and %0d checked sums: sizes 1 to 32, exponents 0 to max,",
             entries_sent, sums_checked);
    $display("unreduced entries, surplus and short loads, and a long output stall.");
    if (errors == 0 && sums_pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

>>> modular_matrix_power_sum.f
sv/mmps_pkg.sv
sv/mmps_if.sv
sv/mmps_ram.sv
sv/mmps_mac.sv
sv/modular_matrix_power_sum.sv
tb/tb_modular_matrix_power_sum.sv
